// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the positional / incremental PID block.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 16;
    localparam int BOUND_W    = 16;
    localparam int LIMIT_W    = 23;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd6;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_prop;
        logic signed [GAIN_W-1:0]  gain_integ;
        logic signed [GAIN_W-1:0]  gain_deriv;
        logic signed [BOUND_W-1:0] drive_floor;
        logic signed [BOUND_W-1:0] drive_ceiling;
        logic        [LIMIT_W-1:0] sum_limit;
        logic                      mode_incremental;
    } cfg_t;

endpackage

// ===== rtl/pid_positional_incremental.sv =====
// ----------------------------------------------------------------------------
// pid_positional_incremental
// PID step per item, positional or incremental form, saturated drive.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per handshake, setpoint and measurement (Q8.8)
//   in tdata, cmd in tuser (1 = clear history, result drive is 0).
//   m_* channel: one drive item per input item, same order.
//   cfg_* channel: register writes, always ready; write only while idle.
// Pipeline: input register -> error/history/operands -> three products
//   -> sum, shift, saturate into the output register. One item per cycle
//   is sustained while m_tready holds high. The history registers update
//   in the operand stage, so each item sees the state left by the one
//   before it with no bubble.
// Backpressure: each stage holds while the next is full and stalled; the
//   block keeps accepting until all four stages are occupied.
// Reset: clears stage valids, history and registers to their defaults
//   (gains 0, floor -32768, ceiling 32767, limit 0, positional mode).
// ----------------------------------------------------------------------------
module pid_positional_incremental #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // setpoint [DW-1:0], measured [2DW-1:DW], zero pad above
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    // cmd
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // drive [DW-1:0], zero pad above
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pip_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import pip_pkg::*;

    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;
    // error sum / older error width
    localparam int SUM_W = (DATA_WIDTH + 1 > LIMIT_W + 1) ? DATA_WIDTH + 1 : LIMIT_W + 1;
    localparam int MAX_W = (DATA_WIDTH + 1 > SUM_W) ? DATA_WIDTH + 1 : SUM_W;
    // e - 2*e1 + e2 needs two bits beyond the widest history term
    localparam int OP_W  = MAX_W + 2;
    localparam int PR_W  = OP_W + GAIN_W;

    cfg_t cfg_reg;

    logic                    in_valid_reg, op_valid_reg, prod_valid_reg, out_valid_reg;
    logic                    in_cmd_reg;
    logic [DATA_WIDTH-1:0]   in_set_reg, in_meas_reg;

    logic                    out_ready, ready3, ready2;
    logic                    load2, load3, load4;

    logic                    op_clear, prod_clear;
    logic signed [OP_W-1:0]  op_p, op_i, op_d;
    logic signed [PR_W-1:0]  prod_p, prod_i, prod_d;
    logic [DATA_WIDTH-1:0]   drive;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop        <= '0;
            cfg_reg.gain_integ       <= '0;
            cfg_reg.gain_deriv       <= '0;
            cfg_reg.drive_floor      <= {1'b1, {(BOUND_W-1){1'b0}}};
            cfg_reg.drive_ceiling    <= {1'b0, {(BOUND_W-1){1'b1}}};
            cfg_reg.sum_limit        <= '0;
            cfg_reg.mode_incremental <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:     cfg_reg.gain_prop        <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG:    cfg_reg.gain_integ       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:    cfg_reg.gain_deriv       <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_FLOOR:   cfg_reg.drive_floor      <= cfg_data[BOUND_W-1:0];
                REG_DRIVE_CEILING: cfg_reg.drive_ceiling    <= cfg_data[BOUND_W-1:0];
                REG_SUM_LIMIT:     cfg_reg.sum_limit        <= cfg_data[LIMIT_W-1:0];
                REG_MODE:          cfg_reg.mode_incremental <= cfg_data[0];
                default:           ;   // unknown index: ignored
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    // each stage moves when it is empty or its successor moves
    assign out_ready = !out_valid_reg || m_tready;
    assign ready3    = !prod_valid_reg || out_ready;
    assign ready2    = !op_valid_reg || ready3;
    assign s_tready  = !in_valid_reg || ready2;

    assign load2 = in_valid_reg && ready2;    // history updates here
    assign load3 = op_valid_reg && ready3;
    assign load4 = prod_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (ready2)
                op_valid_reg <= in_valid_reg;
            if (ready3)
                prod_valid_reg <= op_valid_reg;
            if (out_ready)
                out_valid_reg <= prod_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_set_reg  <= s_tdata[DATA_WIDTH-1:0];
            in_meas_reg <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
    end

    // ---------------- datapath ----------------
    pip_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .SUM_W      (SUM_W),
        .OP_W       (OP_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .load       (load2),
        .cmd        (in_cmd_reg),
        .setpoint   (in_set_reg),
        .measured   (in_meas_reg),
        .clear_reg  (op_clear),
        .op_p_reg   (op_p),
        .op_i_reg   (op_i),
        .op_d_reg   (op_d)
    );

    pip_mult #(
        .OP_W       (OP_W),
        .PR_W       (PR_W)
    ) u_mult (
        .clk        (clk),
        .cfg        (cfg_reg),
        .load       (load3),
        .clear      (op_clear),
        .op_p       (op_p),
        .op_i       (op_i),
        .op_d       (op_d),
        .clear_reg  (prod_clear),
        .prod_p_reg (prod_p),
        .prod_i_reg (prod_i),
        .prod_d_reg (prod_d)
    );

    pip_sat #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .PR_W           (PR_W)
    ) u_sat (
        .clk        (clk),
        .cfg        (cfg_reg),
        .load       (load4),
        .clear      (prod_clear),
        .prod_p     (prod_p),
        .prod_i     (prod_i),
        .prod_d     (prod_d),
        .drive_reg  (drive)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(drive);

endmodule

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// Error, history update and operand selection for both PID forms.
// ----------------------------------------------------------------------------
module pip_front #(
    parameter int DATA_WIDTH = 16,
    parameter int SUM_W      = 24,
    parameter int OP_W       = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pip_pkg::cfg_t                 cfg,
    input  logic                          load,
    input  logic                          cmd,
    input  logic        [DATA_WIDTH-1:0]  setpoint,
    input  logic        [DATA_WIDTH-1:0]  measured,
    output logic                          clear_reg,
    output logic signed [OP_W-1:0]        op_p_reg,
    output logic signed [OP_W-1:0]        op_i_reg,
    output logic signed [OP_W-1:0]        op_d_reg
);
    import pip_pkg::*;

    logic signed [DATA_WIDTH:0]  last_error_reg;
    logic signed [SUM_W-1:0]     sum_reg;

    logic signed [DATA_WIDTH:0]  err;
    logic signed [OP_W-1:0]      e_x, e1_x, e2_x;
    logic signed [SUM_W:0]       sum_raw, lim_x, sum_clamped;
    logic signed [SUM_W-1:0]     sum_new;
    logic signed [OP_W-1:0]      op_p, op_i, op_d;

    assign err = $signed({setpoint[DATA_WIDTH-1], setpoint})
               - $signed({measured[DATA_WIDTH-1], measured});

    assign e_x  = OP_W'(err);
    assign e1_x = OP_W'(last_error_reg);
    assign e2_x = OP_W'(sum_reg);

    // positional error sum, held within +/- limit
    assign sum_raw = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(err);
    assign lim_x   = (SUM_W + 1)'($signed({1'b0, cfg.sum_limit}));

    always_comb
    begin
        if (sum_raw < -lim_x)
            sum_clamped = -lim_x;
        else if (sum_raw > lim_x)
            sum_clamped = lim_x;
        else
            sum_clamped = sum_raw;
    end

    assign sum_new = SUM_W'(sum_clamped);

    always_comb
    begin
        if (cfg.mode_incremental)
        begin
            op_p = e_x - e1_x;
            op_i = e_x;
            op_d = e_x - (e1_x <<< 1) + e2_x;
        end
        else
        begin
            op_p = e_x;
            op_i = OP_W'(sum_new);
            op_d = e_x - e1_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            sum_reg        <= '0;
        end
        else if (load)
        begin
            if (cmd)
            begin
                last_error_reg <= '0;
                sum_reg        <= '0;
            end
            else if (cfg.mode_incremental)
            begin
                sum_reg        <= SUM_W'(last_error_reg);
                last_error_reg <= err;
            end
            else
            begin
                sum_reg        <= sum_new;
                last_error_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            clear_reg <= cmd;
            op_p_reg  <= op_p;
            op_i_reg  <= op_i;
            op_d_reg  <= op_d;
        end
    end

endmodule

// ===== rtl/pip_mult.sv =====
// ----------------------------------------------------------------------------
// pip_mult
// Three gain products, registered.
// ----------------------------------------------------------------------------
module pip_mult #(
    parameter int OP_W = 26,
    parameter int PR_W = 42
) (
    input  logic                   clk,
    input  pip_pkg::cfg_t          cfg,
    input  logic                   load,
    input  logic                   clear,
    input  logic signed [OP_W-1:0] op_p,
    input  logic signed [OP_W-1:0] op_i,
    input  logic signed [OP_W-1:0] op_d,
    output logic                   clear_reg,
    output logic signed [PR_W-1:0] prod_p_reg,
    output logic signed [PR_W-1:0] prod_i_reg,
    output logic signed [PR_W-1:0] prod_d_reg
);
    import pip_pkg::*;

    logic signed [PR_W-1:0] prod_p, prod_i, prod_d;

    assign prod_p = PR_W'(op_p) * PR_W'(cfg.gain_prop);
    assign prod_i = PR_W'(op_i) * PR_W'(cfg.gain_integ);
    assign prod_d = PR_W'(op_d) * PR_W'(cfg.gain_deriv);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            clear_reg  <= clear;
            prod_p_reg <= prod_p;
            prod_i_reg <= prod_i;
            prod_d_reg <= prod_d;
        end
    end

endmodule

// ===== rtl/pip_sat.sv =====
// ----------------------------------------------------------------------------
// pip_sat
// Product sum, fraction shift (floor) and output saturation.
// ----------------------------------------------------------------------------
module pip_sat #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int PR_W           = 42
) (
    input  logic                   clk,
    input  pip_pkg::cfg_t          cfg,
    input  logic                   load,
    input  logic                   clear,
    input  logic signed [PR_W-1:0] prod_p,
    input  logic signed [PR_W-1:0] prod_i,
    input  logic signed [PR_W-1:0] prod_d,
    output logic [DATA_WIDTH-1:0]  drive_reg
);
    import pip_pkg::*;

    localparam int ACC_W = PR_W + 2;

    logic signed [ACC_W-1:0] acc, scaled, lo, hi, sat;

    assign acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    assign scaled = acc >>> GAIN_FRAC_BITS;
    assign lo     = ACC_W'(cfg.drive_floor);
    assign hi     = ACC_W'(cfg.drive_ceiling);

    // floor is tested first: with crossed bounds, values below it give the floor, all others the ceiling
    always_comb
    begin
        if (scaled < lo)
            sat = lo;
        else if (scaled > hi)
            sat = hi;
        else
            sat = scaled;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            drive_reg <= clear ? '0 : sat[DATA_WIDTH-1:0];
    end

endmodule

// ===== rtl/pip_chk.sv =====
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks of the PID block, bound to its top level.
// ----------------------------------------------------------------------------
module pip_chk #(
    parameter int DATA_WIDTH = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata
);
    localparam int DEPTH = 4;    // stages between s_* and m_*
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] flight_reg;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else if (in_acc && !out_acc)
            flight_reg <= flight_reg + 1'b1;
        else if (!in_acc && out_acc)
            flight_reg <= flight_reg - 1'b1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> flight_reg != '0)
        else $error("result without an item in flight");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= CNT_W'(DEPTH))
        else $error("more items in flight than stages");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg == '0 |-> s_tready)
        else $error("empty block not ready");

endmodule

bind pid_positional_incremental pip_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pip_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/pid_positional_incremental_test.sv =====
// ----------------------------------------------------------------------------
// pid_positional_incremental_test
// Self-checking bench for the positional / incremental PID step block.
// A directed table (reset state, field extremes, clear, swapped bounds, mode
// switches, gain and limit extremes, ignored register index) is followed by
// ~1300 random items over randomly configured phases. Every accepted item is
// run through a local PID model and the drive items are checked in order.
// ----------------------------------------------------------------------------
module pid_positional_incremental_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int DW             = 16;
    localparam int FRAC           = 8;
    localparam int NUM_PHASES     = 13;
    localparam int PHASE_ITEMS    = 100;
    localparam int PARK_PHASE     = 3;    // receiver holds off a long stretch
    localparam int DRAIN_PHASE    = 6;    // sender pauses until all drive is back
    localparam int PARK_CYCLES    = 40;
    localparam int SETTLE_CYCLES  = 8;    // pipeline depth plus margin
    localparam int WATCHDOG_LIMIT = 2000;

    // index one past the register list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 3'd7;

    typedef enum logic {CMD_STEP = 1'b0, CMD_CLEAR = 1'b1} pid_cmd_e;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        pid_cmd_e                cmd;
        logic signed [DW-1:0]    setpoint;
        logic signed [DW-1:0]    measured;
        bit                      fixed_want;  // drive typed in by hand
        logic signed [DW-1:0]    want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [2*DW-1:0]         s_tdata   = '0;   // setpoint [15:0], measured [31:16]
    logic                    s_tuser   = 1'b0; // cmd
    logic                    m_tvalid;
    logic                    m_tready  = 1'b1;
    logic [DW-1:0]           m_tdata;          // drive [15:0]
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    pid_positional_incremental #(
        .DATA_WIDTH     (DW),
        .GAIN_FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local PID model: register copy, error history, expected drive items
    // ------------------------------------------------------------------------
    cfg_t                   pid_regs;
    logic signed [16:0]     err_prev;     // e(k-1)
    logic signed [23:0]     err_hist;     // error sum, or e(k-2) in incremental mode
    logic signed [DW-1:0]   drive_q[$];   // drive items still to come out
    int                     fail_count = 0;

    stim_row_t              dir_rows[$];
    bit                     park_req  = 1'b0;
    bit                     rx_choppy = 1'b1;
    bit                     quiet     = 1'b0;

    function automatic void pid_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_PROP:     pid_regs.gain_prop        = data[GAIN_W-1:0];
            REG_GAIN_INTEG:    pid_regs.gain_integ       = data[GAIN_W-1:0];
            REG_GAIN_DERIV:    pid_regs.gain_deriv       = data[GAIN_W-1:0];
            REG_DRIVE_FLOOR:   pid_regs.drive_floor      = data[BOUND_W-1:0];
            REG_DRIVE_CEILING: pid_regs.drive_ceiling    = data[BOUND_W-1:0];
            REG_SUM_LIMIT:     pid_regs.sum_limit        = data[LIMIT_W-1:0];
            REG_MODE:          pid_regs.mode_incremental = data[0];
            default:           ;  // unknown index: nothing changes
        endcase
    endfunction

    // One PID step; updates the history and returns the saturated drive.
    function automatic logic signed [DW-1:0] pid_step(input pid_cmd_e cmd,
                                                      input logic signed [DW-1:0] sp,
                                                      input logic signed [DW-1:0] ms);
        longint e, e1, e2, run_sum, lim, acc, r, kp, ki, kd, lo, hi;
        if (cmd == CMD_CLEAR)
        begin
            err_prev = '0;
            err_hist = '0;
            return '0;
        end
        kp  = $signed(pid_regs.gain_prop);
        ki  = $signed(pid_regs.gain_integ);
        kd  = $signed(pid_regs.gain_deriv);
        lo  = $signed(pid_regs.drive_floor);
        hi  = $signed(pid_regs.drive_ceiling);
        lim = pid_regs.sum_limit;
        e   = longint'(sp) - longint'(ms);
        e1  = err_prev;
        e2  = err_hist;
        if (pid_regs.mode_incremental)
        begin
            acc      = kp * (e - e1) + ki * e + kd * (e - 2 * e1 + e2);
            err_hist = 24'(e1);
        end
        else
        begin
            // sum is pulled back into +-limit, also after a mode switch
            run_sum = e2 + e;
            if (run_sum < -lim)
                run_sum = -lim;
            else if (run_sum > lim)
                run_sum = lim;
            acc      = kp * e + ki * run_sum + kd * (e - e1);
            err_hist = 24'(run_sum);
        end
        err_prev = 17'(e);
        r = acc >>> FRAC;   // floor toward minus infinity
        // floor is tested first: with swapped bounds, values below it give the floor, all others the ceiling
        if (r < lo)
            r = lo;
        else if (r > hi)
            r = hi;
        return DW'(r);
    endfunction

    // ------------------------------------------------------------------------
    // Drive tasks; all called at a rising-edge step
    // ------------------------------------------------------------------------
    task automatic send_item(input pid_cmd_e cmd, input logic signed [DW-1:0] sp,
                             input logic signed [DW-1:0] ms, input bit gappy,
                             input bit fixed_want, input logic signed [DW-1:0] want);
        logic signed [DW-1:0] pred;
        if (gappy && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ms, sp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // accepted at this edge; valid stays up for a possible next item
        pred = pid_step(cmd, sp, ms);
        drive_q.push_back(fixed_want ? want : pred);
    endtask

    // Stop offering items and wait for every drive item to come back.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pid_reg_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void row_item(input pid_cmd_e cmd, input int sp, input int ms,
                                     input bit fixed_want = 1'b0, input int want = 0);
        stim_row_t row;
        row.kind       = ROW_ITEM;
        row.idx        = '0;
        row.data       = '0;
        row.cmd        = cmd;
        row.setpoint   = DW'(sp);
        row.measured   = DW'(ms);
        row.fixed_want = fixed_want;
        row.want       = DW'(want);
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        stim_row_t row;
        row.kind       = ROW_CFG;
        row.idx        = idx;
        row.data       = value;   // negative values keep ones in the upper bits
        row.cmd        = CMD_STEP;
        row.setpoint   = '0;
        row.measured   = '0;
        row.fixed_want = 1'b0;
        row.want       = '0;
        dir_rows.push_back(row);
    endfunction

    // Q8.8 values: extremes, zero, small values, or anything.
    function automatic logic signed [DW-1:0] pick_s16();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return DW'(int'($urandom_range(0, 1024)) - 512);
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return {LIMIT_W{1'b1}};
            2:       return LIMIT_W'($urandom_range(1, 4000));
            default: return LIMIT_W'($urandom());
        endcase
    endfunction

    // Random item: mostly tracking steps (measurement near the target),
    // some wild or extreme values, a few history clears.
    task automatic send_random(input bit gappy);
        int sp, ms;
        case ($urandom_range(0, 11))
            0:
            begin
                send_item(CMD_CLEAR, DW'($urandom()), DW'($urandom()), gappy, 1'b0, '0);
                return;
            end
            1:
            begin
                sp = $urandom_range(0, 1) ? 32767 : -32768;
                ms = $urandom_range(0, 1) ? 32767 : -32768;
            end
            2, 3:
            begin
                sp = $signed(DW'($urandom()));
                ms = $signed(DW'($urandom()));
            end
            default:
            begin
                sp = int'($urandom_range(0, 8191)) - 4096;
                ms = sp + int'($urandom_range(0, 600)) - 300;
            end
        endcase
        send_item(CMD_STEP, DW'(sp), DW'(ms), gappy, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random short stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (park_req)
            begin
                park_req = 1'b0;
                m_tready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && rx_choppy && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive checker: each accepted item against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic signed [DW-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_q.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: unexpected drive item, expected none, got %0d",
                         $time, $signed(m_tdata));
            end
            else
            begin
                want = drive_q.pop_front();
                if (m_tdata !== want)
                begin
                    fail_count++;
                    $display("%0t ns: drive mismatch, expected %0d, got %0d",
                             $time, want, $signed(m_tdata));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic signed [DW-1:0] lo_bound, hi_bound, swap;
        bit                   choppy;

        pid_regs.gain_prop        = '0;
        pid_regs.gain_integ       = '0;
        pid_regs.gain_deriv       = '0;
        pid_regs.drive_floor      = -16'sd32768;
        pid_regs.drive_ceiling    = 16'sd32767;
        pid_regs.sum_limit        = '0;
        pid_regs.mode_incremental = 1'b0;
        err_prev                  = '0;
        err_hist                  = '0;

        // --- directed table ---
        // after reset all gains are zero: drive is 0 at any error
        row_item(CMD_STEP, 32767, -32768, 1'b1, 0);
        row_item(CMD_STEP, -32768, 32767, 1'b1, 0);
        row_item(CMD_CLEAR, 16'h1234, -1, 1'b1, 0);
        // unit proportional gain: drive is the error, saturated
        row_cfg(REG_GAIN_PROP, 256);
        row_item(CMD_STEP, 32767, -32768, 1'b1, 32767);
        row_item(CMD_STEP, -32768, 32767, 1'b1, -32768);
        row_item(CMD_STEP, 100, 40, 1'b1, 60);
        // floor above ceiling: floor is tested first
        row_cfg(REG_DRIVE_FLOOR, 100);
        row_cfg(REG_DRIVE_CEILING, -100);
        row_item(CMD_STEP, 0, 0, 1'b1, 100);
        row_item(CMD_STEP, 500, 0, 1'b1, -100);
        row_item(CMD_CLEAR, 32767, 32767, 1'b1, 0);   // clear ignores the bounds
        // positional with integral wind-up against the limit
        row_cfg(REG_DRIVE_FLOOR, -32768);
        row_cfg(REG_DRIVE_CEILING, 32767);
        row_cfg(REG_GAIN_INTEG, 128);
        row_cfg(REG_GAIN_DERIV, -256);
        row_cfg(REG_SUM_LIMIT, 1000);
        row_item(CMD_STEP, 800, 0);
        row_item(CMD_STEP, 800, 0);
        row_item(CMD_STEP, -32768, 32767);
        row_item(CMD_STEP, -1, -1);
        // switch to incremental with the history as it stands
        row_cfg(REG_MODE, 1);
        row_item(CMD_STEP, 300, 100);
        row_item(CMD_STEP, -300, 100);
        row_item(CMD_STEP, 32767, -32768);
        row_item(CMD_CLEAR, 0, 0, 1'b1, 0);
        row_item(CMD_STEP, 50, -50);
        // back to positional: the stale e(k-2) is clamped into a tight limit
        row_cfg(REG_MODE, 0);
        row_cfg(REG_SUM_LIMIT, 10);
        row_item(CMD_STEP, 0, 0);
        // gain and limit extremes
        row_cfg(REG_GAIN_PROP, -32768);
        row_cfg(REG_GAIN_INTEG, 32767);
        row_cfg(REG_GAIN_DERIV, -32768);
        row_cfg(REG_SUM_LIMIT, 8388607);
        row_item(CMD_STEP, 32767, -32768);
        row_item(CMD_STEP, -32768, 32767);
        row_item(CMD_STEP, 32767, -32768);
        // write past the register list must change nothing
        row_cfg(REG_PAST_END, -1);
        row_item(CMD_STEP, 1, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_pipe();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_item(dir_rows[i].cmd, dir_rows[i].setpoint, dir_rows[i].measured,
                          1'b1, dir_rows[i].fixed_want, dir_rows[i].want);
        end

        // --- random phases, each under a fresh register set ---
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipe();
            quiet     = (phase >= NUM_PHASES - 2);   // no idling at the end
            choppy    = !quiet && (phase % 4 != 2);  // some phases run back to back
            rx_choppy = choppy;

            lo_bound = pick_s16();
            hi_bound = pick_s16();
            if (lo_bound > hi_bound && $urandom_range(0, 4) != 0)
            begin
                swap     = lo_bound;
                lo_bound = hi_bound;
                hi_bound = swap;
            end
            // random upper bits check that only the register width is kept
            cfg_write(REG_GAIN_PROP,     {16'($urandom()), pick_s16()});
            cfg_write(REG_GAIN_INTEG,    {16'($urandom()), pick_s16()});
            cfg_write(REG_GAIN_DERIV,    {16'($urandom()), pick_s16()});
            cfg_write(REG_DRIVE_FLOOR,   {16'($urandom()), lo_bound});
            cfg_write(REG_DRIVE_CEILING, {16'($urandom()), hi_bound});
            cfg_write(REG_SUM_LIMIT,     {9'($urandom()), pick_limit()});
            cfg_write(REG_MODE,          {31'($urandom()), 1'($urandom())});
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_PAST_END, $urandom());

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while items keep coming back to back
                if (phase == PARK_PHASE && n == 30)
                    park_req = 1'b1;
                // sender waits for every drive item mid-phase
                if (phase == DRAIN_PHASE && n == 50)
                    drain_pipe();
                send_random(choppy && !(phase == PARK_PHASE && n >= 30 && n < 60));
            end
        end

        drain_pipe();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_q.size() != 0)
        begin
            fail_count++;
            $display("%0t ns: %0d drive items never arrived", $time, drive_q.size());
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
